### hw/rtl/dpt_pkg.sv
// Shared constants, codes and helper functions of the primality tester.
`default_nettype none
package dpt_pkg;
  localparam int NUMBER_WIDTH = 63;
  localparam int BASE_COUNT   = 7;
  localparam int BASE_W       = 31;
  localparam int SHIFT_W      = $clog2(NUMBER_WIDTH + 1);

  typedef logic [NUMBER_WIDTH-1:0] num_t;

  // Destination of a modular multiply result
  typedef enum logic [1:0] {
    DST_R = 2'd0,
    DST_B = 2'd1,
    DST_Y = 2'd2
  } mul_dst_t;

  // Fixed witness bases
  function automatic logic [BASE_W-1:0] witness_base(input logic [2:0] idx);
    logic [BASE_W-1:0] b;
    unique case (idx)
      3'd0:    b = 31'd2;
      3'd1:    b = 31'd325;
      3'd2:    b = 31'd9375;
      3'd3:    b = 31'd28178;
      3'd4:    b = 31'd450775;
      3'd5:    b = 31'd9780504;
      default: b = 31'd1795265022;
    endcase
    return b;
  endfunction

  // (x + y) mod m for x, y < m
  function automatic num_t add_mod(input num_t x, input num_t y, input num_t m);
    logic [NUMBER_WIDTH:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[NUMBER_WIDTH-1:0];
  endfunction
endpackage
`default_nettype wire

### hw/rtl/deterministic_primality_test_top.sv
// Top level of the deterministic Miller-Rabin primality tester.
//  channel | ports                          | direction
//  input   | in_valid in_ready in_candidate  | in
//  result  | out_valid out_ready out_prime_flag | out
// One candidate at a time; in_ready is low from accept until the result transfers.
// Trivial candidates (below 3 or even) go straight to the result; otherwise each base
// is reduced mod n over its BASE_W bits, then raised to d by square-and-multiply.
// The modular multiplier is bit-serial, one shift-and-add step per cycle.
// Reset is synchronous, active low, and returns the sequencer to idle.
// A stalled result holds in its output register until out_ready.
`default_nettype none
module deterministic_primality_test_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [dpt_pkg::NUMBER_WIDTH-1:0] in_candidate,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_prime_flag
);
  import dpt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TZ   = 8'b0000_0010,
    S_BASE = 8'b0000_0100,
    S_RED  = 8'b0000_1000,
    S_POW  = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_WIT  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  num_t n_r, n_nxt, d_r, d_nxt, e_r, e_nxt, r_r, r_nxt, b_r, b_nxt, y_r, y_nxt;
  num_t acc_r, acc_nxt, add_r, add_nxt, my_r, my_nxt;
  logic [SHIFT_W-1:0] s_r, s_nxt, rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic phase_r, phase_nxt, flag_r, flag_nxt;
  mul_dst_t dst_r, dst_nxt;
  logic [NUMBER_WIDTH:0] red_t;
  logic [BASE_W-1:0] base_v;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_DONE);
  assign out_prime_flag = flag_r;
  assign base_v         = witness_base(idx_r);

  // Sequence the test
  always_comb begin
    state_nxt = state_r; n_nxt = n_r; d_nxt = d_r; e_nxt = e_r; r_nxt = r_r;
    b_nxt = b_r; y_nxt = y_r; acc_nxt = acc_r; add_nxt = add_r; my_nxt = my_r;
    s_nxt = s_r; rnd_nxt = rnd_r; idx_nxt = idx_r; bit_nxt = bit_r;
    phase_nxt = phase_r; flag_nxt = flag_r; dst_nxt = dst_r;
    red_t = {acc_r, base_v[bit_r]};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt = in_candidate;
          d_nxt = in_candidate - num_t'(1);
          s_nxt = '0;
          if (in_candidate == num_t'(2)) begin
            flag_nxt = 1'b1; state_nxt = S_DONE;
          end else if (in_candidate < num_t'(2) || !in_candidate[0]) begin
            flag_nxt = 1'b0; state_nxt = S_DONE;
          end else begin
            state_nxt = S_TZ;
          end
        end
      end
      // Strip trailing zeros of n-1
      S_TZ: begin
        if (d_r[0]) begin
          idx_nxt = '0; state_nxt = S_BASE;
        end else begin
          d_nxt = d_r >> 1; s_nxt = s_r + SHIFT_W'(1);
        end
      end
      S_BASE: begin
        if (idx_r == 3'(BASE_COUNT)) begin
          flag_nxt = 1'b1; state_nxt = S_DONE;
        end else begin
          acc_nxt = '0; bit_nxt = 5'(BASE_W - 1); state_nxt = S_RED;
        end
      end
      // Reduce base mod n, one bit per cycle
      S_RED: begin
        if (red_t >= {1'b0, n_r}) red_t = red_t - {1'b0, n_r};
        acc_nxt = red_t[NUMBER_WIDTH-1:0];
        if (bit_r == '0) begin
          if (red_t == '0) begin
            flag_nxt = 1'b1; state_nxt = S_DONE;
          end else begin
            b_nxt = red_t[NUMBER_WIDTH-1:0]; r_nxt = num_t'(1); e_nxt = d_r;
            phase_nxt = 1'b0; state_nxt = S_POW;
          end
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end
      // Square-and-multiply over the exponent
      S_POW: begin
        if (e_r == '0) begin
          if (r_r == num_t'(1)) begin
            idx_nxt = idx_r + 3'd1; state_nxt = S_BASE;
          end else begin
            y_nxt = r_r; rnd_nxt = '0; state_nxt = S_WIT;
          end
        end else if (e_r[0] && !phase_r) begin
          acc_nxt = '0; add_nxt = r_r; my_nxt = b_r; dst_nxt = DST_R;
          phase_nxt = 1'b1; state_nxt = S_MUL;
        end else begin
          acc_nxt = '0; add_nxt = b_r; my_nxt = b_r; dst_nxt = DST_B;
          phase_nxt = 1'b0; e_nxt = e_r >> 1; state_nxt = S_MUL;
        end
      end
      // Shared modular multiplier: one shift-and-add step per cycle
      S_MUL: begin
        if (my_r == '0) begin
          unique case (dst_r)
            DST_R: begin r_nxt = acc_r; state_nxt = S_POW; end
            DST_B: begin b_nxt = acc_r; state_nxt = S_POW; end
            default: begin
              y_nxt = acc_r; rnd_nxt = rnd_r + SHIFT_W'(1); state_nxt = S_WIT;
            end
          endcase
        end else begin
          if (my_r[0]) acc_nxt = add_mod(acc_r, add_r, n_r);
          add_nxt = add_mod(add_r, add_r, n_r);
          my_nxt  = my_r >> 1;
        end
      end
      // Look for n-1 among the squarings
      S_WIT: begin
        if (rnd_r == s_r) begin
          flag_nxt = 1'b0; state_nxt = S_DONE;
        end else if (y_r == n_r - num_t'(1)) begin
          idx_nxt = idx_r + 3'd1; state_nxt = S_BASE;
        end else begin
          acc_nxt = '0; add_nxt = y_r; my_nxt = y_r; dst_nxt = DST_Y;
          state_nxt = S_MUL;
        end
      end
      default: begin
        if (out_ready) state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk) begin
    n_r <= n_nxt; d_r <= d_nxt; e_r <= e_nxt; r_r <= r_nxt; b_r <= b_nxt;
    y_r <= y_nxt; acc_r <= acc_nxt; add_r <= add_nxt; my_r <= my_nxt;
    s_r <= s_nxt; rnd_r <= rnd_nxt; idx_r <= idx_nxt; bit_r <= bit_nxt;
    phase_r <= phase_nxt; flag_r <= flag_nxt; dst_r <= dst_nxt;
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (acc_r < n_r && add_r < n_r)) else $error("mul operand not reduced");
  a_y_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WIT) |-> (y_r < n_r && rnd_r <= s_r)) else $error("witness state out of range");
`endif
endmodule
`default_nettype wire

### test/prime_check.sv
// Checker for the primality tester: predicts each flag and compares transfers.
`timescale 1ns / 1ps
module prime_check (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire [dpt_pkg::NUMBER_WIDTH-1:0] in_candidate,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire                          out_prime_flag,
  output int                           fail_count,
  output int                           flags_pending,
  output int                           flags_seen,
  output int                           primes_seen
);
  import dpt_pkg::*;

  localparam logic [63:0] WITNESS [7] = '{64'd2, 64'd325, 64'd9375, 64'd28178,
                                           64'd450775, 64'd9780504, 64'd1795265022};

  bit expected_flags[$];

  // (x + y) mod m, operands below m < 2^63
  function automatic logic [63:0] sum_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] t;
    t = x + y;
    return (t >= m) ? t - m : t;
  endfunction

  // shift-and-add modular product
  function automatic logic [63:0] prod_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] acc;
    acc = 0;
    while (y != 0) begin
      if (y[0]) acc = sum_mod(acc, x, m);
      x = sum_mod(x, x, m);
      y = y >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] power_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    r = 1 % m;
    while (e != 0) begin
      if (e[0]) r = prod_mod(r, b, m);
      b = prod_mod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  // Deterministic strong-probable-prime test over the fixed bases
  function automatic bit predict_flag(num_t cand);
    logic [63:0] n, d, a, y;
    int s;
    bit passed;
    n = {1'b0, cand};
    if (n == 2) return 1;
    if (n < 2 || !n[0]) return 0;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < ((BASE_COUNT > 7) ? 7 : BASE_COUNT); i++) begin
      a = WITNESS[i] % n;
      // a base vanishing mod n ends the test as prime
      if (a == 0) break;
      y = power_mod(a, d, n);
      if (y == 1) continue;
      passed = 0;
      for (int r = 0; r < s; r++) begin
        if (y == n - 1) begin
          passed = 1;
          break;
        end
        y = prod_mod(y, y, n);
      end
      if (!passed) return 0;
    end
    return 1;
  endfunction

  initial begin
    fail_count = 0;
    flags_pending = 0;
    flags_seen = 0;
    primes_seen = 0;
  end

  // Push on input transfer, compare on result transfer
  always @(posedge clk) begin
    bit want;
    if (rst_n) begin
      if (in_valid && in_ready) expected_flags.push_back(predict_flag(in_candidate));
      if (out_valid && out_ready) begin
        flags_seen++;
        if (out_prime_flag) primes_seen++;
        if (expected_flags.size() == 0) begin
          $error("prime_flag: unexpected result transfer, actual %0d", out_prime_flag);
          fail_count++;
        end else begin
          want = expected_flags.pop_front();
          if (want !== out_prime_flag) begin
            $error("prime_flag: expected %0d, actual %0d", want, out_prime_flag);
            fail_count++;
          end
        end
      end
      flags_pending = expected_flags.size();
    end
  end
endmodule

### test/deterministic_primality_test_top_tb.sv
// Testbench top: stimulus, handshake pressure and verdict for the primality tester.
`timescale 1ns / 1ps
module deterministic_primality_test_top_tb;
  import dpt_pkg::*;

  localparam int STALL_LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic [NUMBER_WIDTH-1:0] in_candidate = '0;
  logic out_ready = 0;
  logic in_ready, out_valid, out_prime_flag;

  int fail_count, flags_pending, flags_seen, primes_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;
  int sent_count = 0;
  int wide_count = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  deterministic_primality_test_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_candidate(in_candidate),
    .out_valid(out_valid), .out_ready(out_ready), .out_prime_flag(out_prime_flag)
  );

  prime_check checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_candidate(in_candidate),
    .out_valid(out_valid), .out_ready(out_ready), .out_prime_flag(out_prime_flag),
    .fail_count(fail_count), .flags_pending(flags_pending),
    .flags_seen(flags_seen), .primes_seen(primes_seen)
  );

  // Drive result ready: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one candidate and hold it until the transfer
  task automatic offer(input logic [NUMBER_WIDTH-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_candidate <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Mostly small odd values; a few full-width ones since those run long
  function automatic logic [NUMBER_WIDTH-1:0] pick_candidate();
    logic [NUMBER_WIDTH-1:0] v;
    int kind;
    kind = int'($urandom_range(99));
    if (kind < 4) begin
      v = NUMBER_WIDTH'({$urandom, $urandom});
      if (kind < 3) v[0] = 1'b1;
      wide_count++;
    end else if (kind < 70) begin
      v = NUMBER_WIDTH'($urandom_range(4095) | 1);
    end else if (kind < 85) begin
      v = NUMBER_WIDTH'($urandom_range(4095));
    end else begin
      v = NUMBER_WIDTH'($urandom_range(40));
    end
    return v;
  endfunction

  task automatic run_phase(input int count, input int s_pct, input int r_pct,
                           input bit with_hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      // hold the receiver off while the sender keeps offering
      if (with_hold && i == 10) recv_hold <= 3000;
      offer(pick_candidate());
    end
    // pause the sender until every flag has come back
    in_valid <= 1'b0;
    @(posedge clk);
    while (flags_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [NUMBER_WIDTH-1:0] directed [$];
    directed = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd7, 63'd13,
                 63'd561, 63'd2047, 63'd25326001, 63'd3215031751,
                 63'd1000000007, 63'd1795265022, 63'd1795265023,
                 63'h7FFF_FFFF_FFFF_FFFF, 63'd9223372036854775783,
                 63'h7FFF_FFFF_FFFF_FFFE, 63'h5555_5555_5555_5555};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, small primes that vanish a base, strong pseudoprimes
    foreach (directed[i]) offer(directed[i]);
    in_valid <= 1'b0;
    @(posedge clk);
    while (flags_pending != 0) @(posedge clk);

    run_phase(130, 13, 84, 1'b0);
    run_phase(130, 84, 13, 1'b0);
    run_phase(140, 0, 0, 1'b1);

    repeat (200) @(posedge clk);
    $display("Sent %0d candidates (%0d full width), checked %0d flags, %0d prime.",
             sent_count, wide_count, flags_seen, primes_seen);
    $display("Covered stalls on both channels, a long receiver hold-off and drains.");
    if (fail_count == 0 && flags_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
